@@ rtl/shared_buffer_multi_queue_defines.svh @@
// shared_buffer_multi_queue_defines.svh: assertion macros for the multi-queue block
// used by shared_buffer_multi_queue.sv, no other dependencies
`ifndef SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBMQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbmq assertion failed");

// next-cycle implication, checked outside reset
`define SBMQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbmq assertion failed");

`endif

@@ rtl/sbmq_pkg.sv @@
// sbmq_pkg: constants, codes and controller/datapath interface types
// no dependencies
package sbmq_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int DEF_QUEUES  = 4;

  localparam int DATA_W   = 32;
  localparam int QNUM_W   = 2;
  localparam int STATUS_W = 2;

  // opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // commands from the controller
  typedef struct packed {
    logic capture;      // latch the input beat, issue queue and free-list reads
    logic enq_commit;   // link the free entry onto the queue tail, post result
    logic deq_start;    // unlink head, return it to the free list, read data
    logic deq_commit;   // advance the head pointer, post result
    logic fail;         // post a full or empty result, no state change
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic is_deq;
    logic enq_ok;
    logic deq_ok;
    logic out_busy;
  } stat_t;

endpackage

@@ rtl/sbmq_ctrl.sv @@
// sbmq_ctrl: sequencer for one enqueue or dequeue at a time
// depends on sbmq_pkg
module sbmq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sbmq_pkg::stat_t st,
  output sbmq_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DEQ2 = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.is_deq && st.deq_ok) begin
          cmd.deq_start = 1'b1;
          state_next    = S_DEQ2;
        end else if (!st.out_busy) begin
          if (!st.is_deq && st.enq_ok) begin
            cmd.enq_commit = 1'b1;
          end else begin
            cmd.fail = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_DEQ2: begin
        if (!st.out_busy) begin
          cmd.deq_commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/sbmq_datapath.sv @@
// sbmq_datapath: queue pointer store, link table, entry store, free list, result register
// depends on sbmq_pkg
module sbmq_datapath #(
  parameter int ENTRIES = sbmq_pkg::DEF_ENTRIES,
  parameter int QUEUES  = sbmq_pkg::DEF_QUEUES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  opcode,
  input  logic [sbmq_pkg::QNUM_W-1:0]           queue_num,
  input  logic signed [sbmq_pkg::DATA_W-1:0]    data_in,
  input  sbmq_pkg::cmd_t                        cmd,
  output sbmq_pkg::stat_t                       st,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sbmq_pkg::DATA_W-1:0]    data_out,
  output logic [sbmq_pkg::STATUS_W-1:0]         status
);

  localparam int PTR_W  = $clog2(ENTRIES + 1);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QW     = (QIDX_W > sbmq_pkg::QNUM_W) ? QIDX_W : sbmq_pkg::QNUM_W;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

  // latched input beat
  logic                          op_r;
  logic [sbmq_pkg::QNUM_W-1:0]   q_r;
  logic [sbmq_pkg::DATA_W-1:0]   data_r;
  logic                          fresh_r;
  logic                          drained_r;

  // free list and allocation watermark
  logic [PTR_W-1:0] free_head;
  logic [PTR_W-1:0] fill;
  logic [QUEUES-1:0] nonempty;

  // memories
  logic [2*IDX_W-1:0]          q_mem [QUEUES];
  logic [2*IDX_W-1:0]          q_rd;
  logic [PTR_W-1:0]            link_mem [ENTRIES];
  logic [PTR_W-1:0]            link_rd;
  logic [sbmq_pkg::DATA_W-1:0] store_mem [ENTRIES];
  logic [sbmq_pkg::DATA_W-1:0] store_rd;

  // queue number decode
  logic [QW-1:0]     qin_wide;
  logic [QIDX_W-1:0] qin_idx;
  logic              qin_ok;
  logic [QW-1:0]     q_wide;
  logic [QIDX_W-1:0] q_idx;
  logic              q_ok;
  logic              nonempty_q;

  assign qin_wide = QW'(queue_num);
  assign qin_idx  = qin_wide[QIDX_W-1:0];
  assign qin_ok   = ({30'd0, queue_num} < 32'(QUEUES));
  assign q_wide   = QW'(q_r);
  assign q_idx    = q_wide[QIDX_W-1:0];
  assign q_ok     = ({30'd0, q_r} < 32'(QUEUES));
  assign nonempty_q = q_ok ? nonempty[q_idx] : 1'b0;

  logic [IDX_W-1:0] head_rd;
  logic [IDX_W-1:0] tail_rd;
  logic [IDX_W-1:0] free_idx;
  logic             free_avail;

  assign head_rd    = q_rd[2*IDX_W-1:IDX_W];
  assign tail_rd    = q_rd[IDX_W-1:0];
  assign free_idx   = free_head[IDX_W-1:0];
  assign free_avail = (free_head != NIL);

  // memory port controls
  logic             q_we;
  logic [2*IDX_W-1:0] q_wd;
  logic             link_re;
  logic             link_we;
  logic [IDX_W-1:0] link_ra;
  logic [IDX_W-1:0] link_wa;

  assign q_we    = cmd.enq_commit || (cmd.deq_commit && !drained_r);
  assign q_wd    = cmd.enq_commit ? {(nonempty_q ? head_rd : free_idx), free_idx}
                                  : {link_rd[IDX_W-1:0], tail_rd};
  assign link_re = (cmd.capture && free_avail) || cmd.deq_start;
  assign link_ra = cmd.deq_start ? head_rd : free_idx;
  assign link_we = (cmd.enq_commit && nonempty_q) || cmd.deq_start;
  assign link_wa = cmd.deq_start ? head_rd : tail_rd;

  // head/tail pointer store
  always_ff @(posedge clk) begin
    if (cmd.capture && qin_ok) begin
      q_rd <= q_mem[qin_idx];
    end
    if (q_we) begin
      q_mem[q_idx] <= q_wd;
    end
  end

  // link table, read-first; both writes carry the current free head
  always_ff @(posedge clk) begin
    if (link_re) begin
      link_rd <= link_mem[link_ra];
    end
    if (link_we) begin
      link_mem[link_wa] <= free_head;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (cmd.deq_start) begin
      store_rd <= store_mem[head_rd];
    end
    if (cmd.enq_commit) begin
      store_mem[free_idx] <= data_r;
    end
  end

  // input beat capture; entries at or above the watermark were never linked
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode;
      q_r     <= queue_num;
      data_r  <= data_in;
      fresh_r <= (free_head >= fill);
    end
    if (cmd.deq_start) begin
      drained_r <= (head_rd == tail_rd);
    end
  end

  // free list head, watermark and queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
      nonempty  <= '0;
    end else begin
      if (cmd.enq_commit) begin
        free_head         <= fresh_r ? (free_head + 1'b1) : link_rd;
        nonempty[q_idx]   <= 1'b1;
        if (fresh_r) begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.deq_start) begin
        free_head <= PTR_W'(head_rd);
        if (head_rd == tail_rd) begin
          nonempty[q_idx] <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.enq_commit || cmd.deq_commit || cmd.fail) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_commit) begin
      data_out <= '0;
      status   <= sbmq_pkg::ST_DONE;
    end else if (cmd.deq_commit) begin
      data_out <= store_rd;
      status   <= sbmq_pkg::ST_DONE;
    end else if (cmd.fail) begin
      data_out <= '0;
      status   <= (op_r == sbmq_pkg::OP_DEQ) ? sbmq_pkg::ST_EMPTY : sbmq_pkg::ST_FULL;
    end
  end

  // status to the controller
  assign st.is_deq   = (op_r == sbmq_pkg::OP_DEQ);
  assign st.enq_ok   = q_ok && free_avail;
  assign st.deq_ok   = nonempty_q;
  assign st.out_busy = out_valid && out_stall;

endmodule

@@ rtl/shared_buffer_multi_queue.sv @@
// shared_buffer_multi_queue: several fifo queues sharing one linked entry store
// depends on sbmq_pkg, sbmq_ctrl, sbmq_datapath, shared_buffer_multi_queue_defines.svh
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------
//   in      | in_valid / in_stall   | opcode, queue_num, data_in
//   out     | out_valid / out_stall | data_out, status
//
// enqueue and failed operations go through the capture and exec steps, a good dequeue
// also through deq2: the head comes from the pointer store before the link table read.
// one operation is in flight at a time; the result register lets the next beat in
// while a result waits. a stalled result holds the last step of the next operation.
// synchronous active-high reset; no clearing pass, memories start undefined.
`include "shared_buffer_multi_queue_defines.svh"

module shared_buffer_multi_queue #(
  parameter int ENTRIES = sbmq_pkg::DEF_ENTRIES,
  parameter int QUEUES  = sbmq_pkg::DEF_QUEUES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic [sbmq_pkg::QNUM_W-1:0]        queue_num,
  input  logic signed [sbmq_pkg::DATA_W-1:0] data_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sbmq_pkg::DATA_W-1:0] data_out,
  output logic [sbmq_pkg::STATUS_W-1:0]      status
);

  sbmq_pkg::cmd_t  cmd;
  sbmq_pkg::stat_t st;

  // sequencer
  sbmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and result register
  sbmq_datapath #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .opcode    (opcode),
    .queue_num (queue_num),
    .data_in   (data_in),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .status    (status)
  );

  // checks
  logic       commit;
  logic [4:0] cmd_bits;

  assign commit   = cmd.enq_commit || cmd.deq_commit || cmd.fail;
  assign cmd_bits = {cmd.capture, cmd.enq_commit, cmd.deq_start, cmd.deq_commit, cmd.fail};

  `SBMQ_ASSERT_IMP(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd_bits))
  `SBMQ_ASSERT_IMP(a_no_overwrite, clk, rst, commit, !(out_valid && out_stall))
  `SBMQ_ASSERT_NXT(a_commit_shows, clk, rst, commit, out_valid)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for shared_buffer_multi_queue, its own linked-list
// model predicts every result; directed, full-store and random traffic tests
// depends on sbmq_pkg and the shared_buffer_multi_queue rtl
module tb_top;
  import sbmq_pkg::*;

  localparam int NENTRIES = DEF_ENTRIES;
  localparam int NQUEUES = DEF_QUEUES;
  localparam int PTR_W = $clog2(NENTRIES + 1);
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTS = 100;
  localparam int CHUNKS = 26;
  localparam int CHUNK_BEATS = 50;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [QNUM_W-1:0] qnum_t;

  typedef struct {
    word_t data;
    logic [STATUS_W-1:0] status;
  } result_t;

  localparam ptr_t NIL = ptr_t'(NENTRIES);

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_ENQ;
  qnum_t queue_num = '0;
  word_t data_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t data_out;
  logic [STATUS_W-1:0] status;

  // linked-list model state
  ptr_t q_head [NQUEUES];
  ptr_t q_tail [NQUEUES];
  ptr_t link_next [NENTRIES];
  word_t entry_data [NENTRIES];
  ptr_t free_head;

  result_t pending_results[$];
  int mismatch_count = 0;
  int result_index = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit send_idle = 1'b1;
  bit rcv_idle = 1'b1;

  shared_buffer_multi_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .queue_num(queue_num),
    .data_in(data_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data_out(data_out),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // model state after reset: all queues empty, every entry on the free list
  task automatic clear_queue_model();
    for (int i = 0; i < NQUEUES; i++) begin
      q_head[i] = NIL;
      q_tail[i] = NIL;
    end
    for (int i = 0; i < NENTRIES; i++) begin
      link_next[i] = ptr_t'(i + 1);
      entry_data[i] = '0;
    end
    link_next[NENTRIES-1] = NIL;
    free_head = '0;
  endtask

  // apply one enqueue or dequeue to the model and return its result
  function automatic result_t apply_queue_op(logic op, qnum_t q, word_t d);
    result_t r;
    ptr_t e;
    r.data = '0;
    r.status = ST_DONE;
    if (op == OP_ENQ) begin
      e = free_head;
      if (int'(q) >= NQUEUES || e == NIL) begin
        r.status = ST_FULL;
      end else begin
        free_head = link_next[e];
        if (q_head[q] == NIL) begin
          q_head[q] = e;
        end else begin
          link_next[q_tail[q]] = e;
        end
        link_next[e] = NIL;
        q_tail[q] = e;
        entry_data[e] = d;
      end
    end else begin
      if (int'(q) >= NQUEUES || q_head[q] == NIL) begin
        r.status = ST_EMPTY;
      end else begin
        e = q_head[q];
        r.data = entry_data[e];
        q_head[q] = link_next[e];
        // last entry gone, queue is empty again
        if (q_head[q] == NIL) q_tail[q] = NIL;
        link_next[e] = free_head;
        free_head = e;
      end
    end
    return r;
  endfunction

  // one line per mismatch, printing capped so a broken block stays readable
  task automatic report_mismatch(string what, logic [DATA_W-1:0] want_v,
                                 logic [DATA_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("mismatch at %0t, result %0d: %s expected %h got %h",
               $time, result_index, what, want_v, got_v);
    end
  endtask

  // send one input beat, hold it until accepted, then predict its result
  task automatic send_beat(logic op, qnum_t q, word_t d);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    queue_num <= q;
    data_in <= d;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(apply_queue_op(op, q, d));
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // dequeue from every queue while all are empty
  task automatic test_empty_queues();
    for (int q = 0; q < NQUEUES; q++) send_beat(OP_DEQ, qnum_t'(q), $urandom);
  endtask

  // extreme data values through different queues, then drain each queue
  task automatic test_field_extremes();
    word_t vals [6];
    vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
             32'haaaa_aaaa, 32'h5555_5555};
    for (int i = 0; i < 6; i++) send_beat(OP_ENQ, qnum_t'(i % NQUEUES), vals[i]);
    send_beat(OP_DEQ, 2'd1, 32'hffff_ffff);
    send_beat(OP_DEQ, 2'd1, '0);
    send_beat(OP_DEQ, 2'd1, '0);
    send_beat(OP_DEQ, 2'd0, '0);
    send_beat(OP_DEQ, 2'd0, '0);
    send_beat(OP_DEQ, 2'd2, '0);
    send_beat(OP_DEQ, 2'd3, '0);
  endtask

  // receiver holds off for a long stretch while the store fills and overflows
  task automatic test_store_full();
    send_idle = 1'b0;
    hold_cycles = 200;
    for (int i = 0; i < NENTRIES + 4; i++) begin
      send_beat(OP_ENQ, qnum_t'(i % NQUEUES), $urandom);
    end
    wait_drained();
    send_idle = 1'b1;
  endtask

  // empty every queue, one extra dequeue each once drained
  task automatic test_drain_all();
    for (int q = 0; q < NQUEUES; q++) begin
      repeat (NENTRIES / NQUEUES + 1) send_beat(OP_DEQ, qnum_t'(q), $urandom);
    end
  endtask

  // random traffic in chunks that lean toward filling or emptying the store, or stay balanced
  task automatic test_random_traffic();
    int enq_pct;
    int mode;
    logic op;
    word_t d;
    for (int c = 0; c < CHUNKS; c++) begin
      enq_pct = (c % 3 == 0) ? 80 : (c % 3 == 1) ? 25 : 50;
      mode = $urandom_range(0, 3);
      send_idle = mode[0];
      rcv_idle = mode[1];
      for (int i = 0; i < CHUNK_BEATS; i++) begin
        op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
        d = $urandom;
        case ($urandom_range(0, 15))
          0: d = 32'h8000_0000;
          1: d = 32'h7fff_ffff;
          2: d = 32'hffff_ffff;
          3: d = '0;
          default: ;
        endcase
        send_beat(op, qnum_t'($urandom_range(0, NQUEUES - 1)), d);
      end
      // now and then the sender waits for every result before going on
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    send_idle = 1'b1;
    rcv_idle = 1'b1;
  endtask

  // receiver stall: a long hold when a test sets one, else a random wait after each beat if rcv_idle
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        stall_left = rcv_idle ? $urandom_range(0, 5) : 0;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result beat with the oldest prediction
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst == 1'b0 && out_valid === 1'b1 && out_stall == 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", '0, data_out);
        end else begin
          want = pending_results.pop_front();
          if (data_out !== want.data) report_mismatch("data_out", want.data, data_out);
          if (status !== want.status) begin
            report_mismatch("status", DATA_W'(want.status), DATA_W'(status));
          end
        end
        result_index++;
      end
    end
  end

  // watchdog: too long without any beat on either channel
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // test sequence
  initial begin
    clear_queue_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_queues();
    test_field_extremes();
    test_store_full();
    test_drain_all();
    test_random_traffic();
    wait_drained();
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived", pending_results.size(), '0);
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
